>>> rtl/sie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sie_pkg;

   localparam int DEPTH_DEF = 1024;
   localparam int POS_W     = 11;
   localparam int VAL_W     = 32;
   localparam int FILL_W    = 11;
   localparam int CAP_W     = 12;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_ERASE  = 2'd1;
   localparam logic [1:0] CMD_GET    = 2'd2;
   localparam logic [1:0] CMD_SET    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] item_value;
      logic [POS_W-1:0]        erase_count;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [FILL_W-1:0]       fill_count;
      logic [CAP_W-1:0]        capacity_model;
      logic [1:0]              status;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/sie_store.sv
`timescale 1ns / 1ps
`default_nettype none
module sie_store #(
   parameter int DEPTH = sie_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                            clock,
   input  wire logic                            rd_en,
   input  wire logic [AW-1:0]                   rd_addr,
   output logic signed [sie_pkg::VAL_W-1:0]     rd_data,
   input  wire logic                            wr_en,
   input  wire logic [AW-1:0]                   wr_addr,
   input  wire logic signed [sie_pkg::VAL_W-1:0] wr_data
);

   logic signed [sie_pkg::VAL_W-1:0] mem [DEPTH];
   logic signed [sie_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/sie_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sie_ctrl #(
   parameter int DEPTH = sie_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire sie_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output sie_pkg::rsp_type                      rsp_data,
   output logic                                  rd_en,
   output logic [AW-1:0]                         rd_addr,
   input  wire logic signed [sie_pkg::VAL_W-1:0] rd_data,
   output logic                                  wr_en,
   output logic [AW-1:0]                         wr_addr,
   output logic signed [sie_pkg::VAL_W-1:0]      wr_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = CW + 1;
   localparam int EW = ((CW > sie_pkg::POS_W) ? CW : sie_pkg::POS_W) + 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_SHIFT_UP = 3'd2;
   localparam logic [2:0] S_INS_WR   = 3'd3;
   localparam logic [2:0] S_SHIFT_DN = 3'd4;
   localparam logic [2:0] S_GET_WAIT = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]                       state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [KW-1:0]                    cap_ff, cap_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                    ptr_ff, ptr_in;
   logic [1:0]                       status_ff, status_in;
   logic signed [sie_pkg::VAL_W-1:0] read_ff, read_in;
   sie_pkg::req_type                 req_ff, req_in;
   sie_pkg::rsp_type                 rsp_ff, rsp_in;

   logic [EW-1:0] pos_e, cnt_e, cnt_end, count_e, count_m1, count_p1, ptr_e;
   logic [EW-1:0] ptr_p1, ptr_m1, ptr_dn, count_dn, cap_e;
   logic          rsp_free;

   always_comb begin
      pos_e    = EW'(req_ff.position);
      cnt_e    = EW'(req_ff.erase_count);
      cnt_end  = pos_e + cnt_e;
      count_e  = EW'(count_ff);
      count_m1 = count_e - EW'(1);
      count_p1 = count_e + EW'(1);
      count_dn = count_e - cnt_e;
      ptr_e    = EW'(ptr_ff);
      ptr_p1   = ptr_e + EW'(1);
      ptr_m1   = ptr_e - EW'(1);
      ptr_dn   = ptr_e - cnt_e;
      cap_e    = EW'(cap_ff);
      rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      ptr_in       = ptr_ff;
      status_in    = status_ff;
      read_in      = read_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               status_in = sie_pkg::ST_OK;
               read_in   = '0;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (req_ff.cmd)
               sie_pkg::CMD_INSERT: begin
                  if (pos_e > count_e) begin
                     status_in = sie_pkg::ST_RANGE;
                  end else if (count_e == EW'(DEPTH)) begin
                     status_in = sie_pkg::ST_FULL;
                  end else if (pos_e == count_e) begin
                     state_in = S_INS_WR;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = count_m1[AW-1:0];
                     ptr_in   = count_m1[AW-1:0];
                     state_in = S_SHIFT_UP;
                  end
               end
               sie_pkg::CMD_ERASE: begin
                  if (cnt_end > count_e) begin
                     status_in = sie_pkg::ST_RANGE;
                  end else if (cnt_e == '0 || cnt_end == count_e) begin
                     count_in = count_dn[CW-1:0];
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = cnt_end[AW-1:0];
                     ptr_in   = cnt_end[AW-1:0];
                     state_in = S_SHIFT_DN;
                  end
               end
               sie_pkg::CMD_GET: begin
                  if (pos_e >= count_e) begin
                     status_in = sie_pkg::ST_RANGE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = pos_e[AW-1:0];
                     state_in = S_GET_WAIT;
                  end
               end
               default: begin
                  if (pos_e >= count_e) begin
                     status_in = sie_pkg::ST_RANGE;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = pos_e[AW-1:0];
                     wr_data = req_ff.item_value;
                  end
               end
            endcase
         end
         S_SHIFT_UP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_p1[AW-1:0];
            if (ptr_e == pos_e) begin
               state_in = S_INS_WR;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_m1[AW-1:0];
               ptr_in  = ptr_m1[AW-1:0];
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_e[AW-1:0];
            wr_data  = req_ff.item_value;
            count_in = count_p1[CW-1:0];
            if (cap_e == count_p1) begin
               cap_in = cap_ff << 1;
            end
            state_in = S_DONE;
         end
         S_SHIFT_DN: begin
            wr_en   = 1'b1;
            wr_addr = ptr_dn[AW-1:0];
            if (ptr_e == count_m1) begin
               count_in = count_dn[CW-1:0];
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_p1[AW-1:0];
               ptr_in  = ptr_p1[AW-1:0];
            end
         end
         S_GET_WAIT: begin
            read_in  = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_in.read_value     = read_ff;
               rsp_in.fill_count     = count_e[sie_pkg::FILL_W-1:0];
               rsp_in.capacity_model = cap_e[sie_pkg::CAP_W-1:0];
               rsp_in.status         = status_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= KW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      read_ff   <= read_in;
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/shift_insert_erase_array.sv
// steps: idle takes a beat, decode checks it and a set writes, a get waits for the read,
// insert shifts later entries up then writes, erase shifts them down, done posts result
// throughput: one beat in flight; the store's single write port moves one entry per cycle
// a waiting result sits in an output register while the next beat is processed
// reset: synchronous, fill count 0, capacity 1; store contents are kept, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module shift_insert_erase_array #(
   parameter int DEPTH = sie_pkg::DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sie_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sie_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);

   logic                             rd_en, wr_en;
   logic [AW-1:0]                    rd_addr, wr_addr;
   logic signed [sie_pkg::VAL_W-1:0] rd_data, wr_data;

   sie_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   sie_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && (rd_addr == wr_addr)))
      else $error("store read and write hit the same entry");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new beat taken while one is in flight");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < (AW+1)'(DEPTH)))
      else $error("store write beyond depth");

   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ({1'b0, rd_addr} < (AW+1)'(DEPTH)))
      else $error("store read beyond depth");

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int STORE_DEPTH  = sie_pkg::DEPTH_DEF;
   localparam int HOLD_CYCLES  = 300;
   localparam int SOFT_FILL    = 96;
   localparam int DRAIN_CYCLES = 1100;

   class insert_erase_scoreboard;
      logic [sie_pkg::VAL_W-1:0] words [sie_pkg::DEPTH_DEF];
      int unsigned               held;
      int unsigned               capacity;
      sie_pkg::rsp_type          pending_responses [$];
      int unsigned               mismatch_count;

      function new();
         held = 0;
         capacity = 1;
         mismatch_count = 0;
      endfunction

      task report(string what);
         if (mismatch_count < 100) $display("%0t mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      function sie_pkg::rsp_type apply_command(sie_pkg::req_type beat);
         sie_pkg::rsp_type outcome;
         int unsigned      pos;
         int unsigned      run;
         int unsigned      i;
         outcome = '0;
         outcome.status = sie_pkg::ST_OK;
         pos = beat.position;
         run = beat.erase_count;
         case (beat.cmd)
            sie_pkg::CMD_INSERT: begin
               if (pos > held)
                  outcome.status = sie_pkg::ST_RANGE;
               else if (held >= sie_pkg::DEPTH_DEF)
                  outcome.status = sie_pkg::ST_FULL;
               else begin
                  for (i = held; i > pos; i--) words[i] = words[i-1];
                  words[pos] = beat.item_value;
                  held++;
                  while (capacity <= held) capacity = capacity << 1;
               end
            end
            sie_pkg::CMD_ERASE: begin
               if (pos + run > held)
                  outcome.status = sie_pkg::ST_RANGE;
               else if (run != 0) begin
                  for (i = pos + run; i < held; i++) words[i-run] = words[i];
                  held -= run;
               end
            end
            sie_pkg::CMD_GET: begin
               if (pos >= held)
                  outcome.status = sie_pkg::ST_RANGE;
               else
                  outcome.read_value = words[pos];
            end
            default: begin
               if (pos >= held)
                  outcome.status = sie_pkg::ST_RANGE;
               else
                  words[pos] = beat.item_value;
            end
         endcase
         outcome.fill_count = held[sie_pkg::FILL_W-1:0];
         outcome.capacity_model = capacity[sie_pkg::CAP_W-1:0];
         return outcome;
      endfunction

      function void note_request(sie_pkg::req_type beat);
         pending_responses.push_back(apply_command(beat));
      endfunction

      task check_response(sie_pkg::rsp_type seen);
         sie_pkg::rsp_type want;
         if (pending_responses.size() == 0) begin
            report($sformatf("response beat with nothing expected, fill %0d",
                             seen.fill_count));
            return;
         end
         want = pending_responses.pop_front();
         if (seen.read_value !== want.read_value)
            report($sformatf("read_value %0d, expected %0d",
                             seen.read_value, want.read_value));
         if (seen.fill_count !== want.fill_count)
            report($sformatf("fill_count %0d, expected %0d",
                             seen.fill_count, want.fill_count));
         if (seen.capacity_model !== want.capacity_model)
            report($sformatf("capacity_model %0d, expected %0d",
                             seen.capacity_model, want.capacity_model));
         if (seen.status !== want.status)
            report($sformatf("status %0d, expected %0d", seen.status, want.status));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sie_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sie_pkg::rsp_type rsp_data;

   int unsigned send_idle_pct = 9;
   int unsigned recv_idle_pct = 80;
   int unsigned beats_sent = 0;
   bit          hold_pending = 1'b0;
   insert_erase_scoreboard tracker;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   shift_insert_erase_array #(.DEPTH(STORE_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // receiver, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_response(rsp_data);
   end

   task automatic send_beat(input logic [1:0] cmd, input int unsigned pos,
                            input logic [sie_pkg::VAL_W-1:0] value,
                            input int unsigned run);
      sie_pkg::req_type beat;
      beat.cmd = cmd;
      beat.position = pos[sie_pkg::POS_W-1:0];
      beat.item_value = value;
      beat.erase_count = run[sie_pkg::POS_W-1:0];
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(beat);
      beats_sent++;
   endtask

   task automatic random_round();
      int unsigned kind;
      int unsigned start;
      int unsigned runs;
      int unsigned k;
      kind = $urandom_range(99);
      if (kind < 35 && tracker.held < SOFT_FILL) begin
         // batch insert at rising positions
         start = $urandom_range(tracker.held);
         runs = $urandom_range(8, 1);
         for (k = 0; k < runs; k++)
            send_beat(sie_pkg::CMD_INSERT, start + k, $urandom, $urandom_range(2047));
      end else if (kind < 55) begin
         start = $urandom_range(tracker.held);
         runs = $urandom_range(tracker.held - start + 1);
         send_beat(sie_pkg::CMD_ERASE, start, $urandom, runs);
      end else if (kind < 88) begin
         start = $urandom_range(tracker.held);
         send_beat($urandom_range(1) ? sie_pkg::CMD_SET : sie_pkg::CMD_GET, start,
                   $urandom, $urandom_range(2047));
      end else
         send_beat(2'($urandom_range(3)), $urandom_range(2047), $urandom,
                   $urandom_range(2047));
   endtask

   initial begin
      int unsigned pos;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty store
      send_beat(sie_pkg::CMD_GET,    0, '0, 0);
      send_beat(sie_pkg::CMD_SET,    0, 32'h1234_5678, 0);
      send_beat(sie_pkg::CMD_ERASE,  0, '0, 0);
      send_beat(sie_pkg::CMD_ERASE,  0, '0, 1);
      send_beat(sie_pkg::CMD_INSERT, 1, 32'h0000_0001, 0);
      // front, end and middle inserts with extreme values
      send_beat(sie_pkg::CMD_INSERT, 0, 32'h7fff_ffff, 0);
      send_beat(sie_pkg::CMD_INSERT, 0, 32'h8000_0000, 2047);
      send_beat(sie_pkg::CMD_INSERT, 2, 32'hffff_ffff, 0);
      send_beat(sie_pkg::CMD_INSERT, 1, 32'h0000_0000, 0);
      send_beat(sie_pkg::CMD_INSERT, 2047, 32'h0000_0005, 0);
      for (pos = 0; pos < 4; pos++) send_beat(sie_pkg::CMD_GET, pos, '0, 0);
      send_beat(sie_pkg::CMD_SET, 3, 32'h5555_5555, 0);
      send_beat(sie_pkg::CMD_SET, 0, 32'haaaa_aaaa, 0);
      send_beat(sie_pkg::CMD_GET, 3, '0, 0);
      send_beat(sie_pkg::CMD_GET, 4, '0, 0);
      // erase runs, zero-length and past the end
      send_beat(sie_pkg::CMD_ERASE, 1, '0, 2);
      send_beat(sie_pkg::CMD_ERASE, 1, '0, 2047);
      send_beat(sie_pkg::CMD_ERASE, 2047, '0, 0);
      send_beat(sie_pkg::CMD_ERASE, 2, '0, 0);
      send_beat(sie_pkg::CMD_GET, 1, '0, 0);
      send_beat(sie_pkg::CMD_ERASE, 0, '0, 2);
      send_beat(sie_pkg::CMD_GET, 0, '0, 0);
      send_beat(sie_pkg::CMD_SET, 2047, 32'hffff_ffff, 2047);

      while (beats_sent < 200) random_round();
      send_idle_pct = 80;
      recv_idle_pct = 9;
      while (beats_sent < 380) random_round();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_pending = 1'b1;
      while (beats_sent < 565) random_round();

      // range cases at and past the top of the store
      send_beat(sie_pkg::CMD_INSERT, STORE_DEPTH, 32'h0bad_0001, 0);
      send_beat(sie_pkg::CMD_INSERT, 0, 32'h0bad_0002, 0);
      send_beat(sie_pkg::CMD_INSERT, STORE_DEPTH + 1, 32'h0bad_0003, 0);
      send_beat(sie_pkg::CMD_GET, STORE_DEPTH - 1, '0, 0);
      send_beat(sie_pkg::CMD_SET, STORE_DEPTH - 1, 32'hdead_beef, 0);
      send_beat(sie_pkg::CMD_GET, STORE_DEPTH - 1, '0, 0);
      send_beat(sie_pkg::CMD_GET, STORE_DEPTH, '0, 0);
      send_beat(sie_pkg::CMD_ERASE, 0, '0, 1);
      send_beat(sie_pkg::CMD_INSERT, 0, 32'h8000_0001, 0);
      send_beat(sie_pkg::CMD_GET, 0, '0, 0);
      send_beat(sie_pkg::CMD_ERASE, 0, '0, STORE_DEPTH);
      send_beat(sie_pkg::CMD_GET, 0, '0, 0);
      req_valid <= 1'b0;

      while (tracker.pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending_responses.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
